// ----- hdl/htfe_pkg.sv -----
`default_nettype none
package htfe_pkg;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int TRAILER_RUN = 3;
  localparam int BYTE_W = 8;
  localparam int POS_W = 6;
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int IDX_W = $clog2(MAX_FRAME_BYTES);
  localparam int ADDR_W = IDX_W + 1;
  localparam int CFG_IDX_W = 8;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_HEADER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER = CFG_IDX_W'(1);

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h5A;
  localparam logic [BYTE_W-1:0] TRAILER_RESET = 8'hFF;

  typedef struct packed {
    logic en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic bank;
    logic [CNT_W-1:0] len;
  } desc_t;

  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

endpackage
`default_nettype wire

// ----- hdl/htfe_front.sv -----
`default_nettype none
module htfe_front
  import htfe_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire logic [BYTE_W-1:0]    rx_byte,
  output logic                      full,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data,
  output mem_wr_t                   wr,
  output logic                      desc_push,
  output desc_t                     desc,
  input  wire rel_t                 rel
);

  logic [BYTE_W-1:0] header_value;
  logic [BYTE_W-1:0] trailer_value;
  logic              collecting;
  logic              collecting_next;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  fill_next;
  logic [CNT_W-1:0]  fill_inc;
  logic [BYTE_W-1:0] t1;
  logic [BYTE_W-1:0] t2;
  logic [1:0]        busy;
  logic [1:0]        busy_next;
  logic              wbank;
  logic              wbank_next;
  logic              accept;
  logic              trailer_hit;

  assign full = busy[wbank];
  assign accept = push && !full;
  assign fill_inc = fill + CNT_W'(1);

  always_comb begin
    collecting_next = collecting;
    fill_next = fill;
    wbank_next = wbank;
    busy_next = busy;
    wr = '0;
    desc_push = 1'b0;
    desc.bank = wbank;
    desc.len = fill_inc;
    trailer_hit = (fill_inc >= CNT_W'(TRAILER_RUN)) && (rx_byte == trailer_value)
      && (t1 == trailer_value) && (t2 == trailer_value);
    if (rel.en) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (accept) begin
      if (!collecting) begin
        if (rx_byte == header_value) begin
          wr.en = 1'b1;
          wr.addr = {wbank, IDX_W'(0)};
          wr.data = rx_byte;
          fill_next = CNT_W'(1);
          collecting_next = 1'b1;
        end
      end else if (fill >= CNT_W'(MAX_FRAME_BYTES)) begin
        fill_next = '0;
        collecting_next = 1'b0;
      end else begin
        wr.en = 1'b1;
        wr.addr = {wbank, fill[IDX_W-1:0]};
        wr.data = rx_byte;
        if (trailer_hit) begin
          desc_push = 1'b1;
          busy_next[wbank] = 1'b1;
          wbank_next = !wbank;
          fill_next = '0;
          collecting_next = 1'b0;
        end else if (fill_inc >= CNT_W'(MAX_FRAME_BYTES)) begin
          fill_next = '0;
          collecting_next = 1'b0;
        end else begin
          fill_next = fill_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= HEADER_RESET;
      trailer_value <= TRAILER_RESET;
      collecting <= 1'b0;
      fill <= '0;
      busy <= '0;
      wbank <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_HEADER) begin
          header_value <= cfg_data;
        end else if (cfg_index == REG_TRAILER) begin
          trailer_value <= cfg_data;
        end
      end
      collecting <= collecting_next;
      fill <= fill_next;
      busy <= busy_next;
      wbank <= wbank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      t2 <= t1;
      t1 <= rx_byte;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/htfe_queue.sv -----
`default_nettype none
module htfe_queue
  import htfe_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire desc_t push_desc,
  input  wire logic  pop,
  output logic       valid,
  output desc_t      head
);

  desc_t              slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr;
  logic [Q_PTR_W-1:0] rptr;
  logic [Q_CNT_W-1:0] count;

  assign valid = (count != '0);
  assign head = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wptr + Q_PTR_W'(1);
      end
      if (pop && valid) begin
        rptr <= (rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rptr + Q_PTR_W'(1);
      end
      count <= count + Q_CNT_W'(push) - Q_CNT_W'(pop && valid);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_desc;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != Q_CNT_W'(Q_DEPTH)))
    else $error("descriptor queue overflow");

endmodule
`default_nettype wire

// ----- hdl/htfe_back.sv -----
`default_nettype none
module htfe_back
  import htfe_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mem_wr_t        wr,
  input  wire logic           desc_valid,
  input  wire desc_t          desc,
  output logic                desc_pop,
  output rel_t                rel,
  output logic                empty,
  input  wire logic           pop,
  output logic [BYTE_W-1:0]   frame_byte,
  output logic [POS_W-1:0]    byte_position,
  output logic                last_of_frame
);

  logic [BYTE_W-1:0] mem [2**ADDR_W];
  logic              active;
  logic              bank;
  logic [CNT_W-1:0]  len;
  logic [IDX_W-1:0]  idx;
  logic              ov;
  logic              rd_en;
  logic              issue_last;

  assign desc_pop = desc_valid && !active;
  assign rd_en = active && (!ov || pop);
  assign issue_last = (CNT_W'(idx) == len - CNT_W'(1));
  assign rel.en = rd_en && issue_last;
  assign rel.bank = bank;
  assign empty = !ov;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      frame_byte <= mem[{bank, idx}];
      byte_position <= POS_W'(idx);
      last_of_frame <= issue_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      ov <= 1'b0;
      idx <= '0;
    end else begin
      if (desc_pop) begin
        active <= 1'b1;
        bank <= desc.bank;
        len <= desc.len;
        idx <= '0;
      end else if (rd_en) begin
        idx <= idx + IDX_W'(1);
        if (issue_last) begin
          active <= 1'b0;
        end
      end
      if (rd_en) begin
        ov <= 1'b1;
      end else if (pop) begin
        ov <= 1'b0;
      end
    end
  end

  a_min_frame: assert property (@(posedge clk) disable iff (rst)
    desc_pop |-> (desc.len >= CNT_W'(TRAILER_RUN)))
    else $error("frame shorter than trailer run");

  a_idx_in_frame: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (CNT_W'(idx) < len))
    else $error("read past end of frame");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    rel.en |=> (!active && ov && last_of_frame))
    else $error("frame end not marked");

endmodule
`default_nettype wire

// ----- hdl/header_trailer_frame_extractor.sv -----
// header/trailer byte-stream deframer
// input channel: rx_byte with push/full, one received byte per transfer.
// bytes are ignored until one equals header_value; from then on every byte
// is stored until the last three stored bytes equal trailer_value. the
// complete frame (header and trailer included) is then replayed on the
// result channel, one byte per transfer, with byte_position on every byte
// and last_of_frame on the final byte. a frame that reaches the store limit
// without a trailer is dropped with no result.
// result channel: empty/pop, the oldest byte shows while empty is low.
// config channel: cfg_valid/cfg_ready, index 0 header_value, 1 trailer_value;
// cfg_ready is always high.
// input takes one byte per cycle while full is low. once the final trailer
// byte is taken, the frame's descriptor is written into the queue, the read
// side loads it when idle and registers the first frame byte onto the result
// ports, then one byte per cycle while pop is high. the frame store is two
// banks of 64 bytes, so one frame may drain while the next is collected; full
// rises only when both banks hold frames not yet drained.
// reset: registers to 0x5a / 0xff, hunting for header, nothing pending.
// a stalled pop holds the current byte and, once both banks are taken,
// holds off input through full.
`default_nettype none
module header_trailer_frame_extractor
  import htfe_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [BYTE_W-1:0]    rx_byte,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [BYTE_W-1:0]         frame_byte,
  output logic [POS_W-1:0]          byte_position,
  output logic                      last_of_frame,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data
);

  mem_wr_t wr;
  desc_t   front_desc;
  desc_t   head_desc;
  rel_t    rel;
  logic    desc_push;
  logic    desc_valid;
  logic    desc_pop;

  assign cfg_ready = 1'b1;

  htfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .rx_byte   (rx_byte),
    .full      (full),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr        (wr),
    .desc_push (desc_push),
    .desc      (front_desc),
    .rel       (rel)
  );

  htfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (desc_push),
    .push_desc (front_desc),
    .pop       (desc_pop),
    .valid     (desc_valid),
    .head      (head_desc)
  );

  htfe_back u_back (
    .clk           (clk),
    .rst           (rst),
    .wr            (wr),
    .desc_valid    (desc_valid),
    .desc          (head_desc),
    .desc_pop      (desc_pop),
    .rel           (rel),
    .empty         (empty),
    .pop           (pop),
    .frame_byte    (frame_byte),
    .byte_position (byte_position),
    .last_of_frame (last_of_frame)
  );

endmodule
`default_nettype wire
